// ----- hdl/mts_pkg.sv -----
`default_nettype none
package mts_pkg;

	// proposed type codes on the input
	localparam logic [3:0] PROP_NONE  = 4'd0;
	localparam logic [3:0] PROP_HTML  = 4'd1;
	localparam logic [3:0] PROP_PLAIN = 4'd6;
	localparam logic [3:0] PROP_OTHER = 4'd8;

	// result codes
	localparam logic [2:0] MIME_HTML  = 3'd0;
	localparam logic [2:0] MIME_GIF   = 3'd1;
	localparam logic [2:0] MIME_JPEG  = 3'd2;
	localparam logic [2:0] MIME_PNG   = 3'd3;
	localparam logic [2:0] MIME_BMP   = 3'd4;
	localparam logic [2:0] MIME_PLAIN = 3'd5;
	localparam logic [2:0] MIME_OCTET = 3'd6;
	localparam logic [2:0] MIME_OTHER = 3'd7;

	// match flags for the buffer, valid on its final byte
	typedef struct packed {
		logic html;
		logic gif;
		logic jpeg;
		logic png;
		logic bmp;
		logic plain;
	} mts_hits_t;

endpackage
`default_nettype wire

// ----- hdl/mts_scan.sv -----
`default_nettype none
module mts_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              consume,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output mts_pkg::mts_hits_t     hits
);
	import mts_pkg::*;

	localparam logic [3:0] POS_MAX = 4'd15;

	logic [3:0] pos_q;
	logic [2:0] prog_q;
	logic       seen_q;
	logic       gif_q;
	logic       jpeg_q;
	logic       png_q;
	logic       bmp_q;
	logic       plain_q;

	logic [7:0] low;
	logic [7:0] tail_chr;
	logic [7:0] png_chr;
	logic       html_adv;
	logic [2:0] prog_n;
	logic       seen_n;
	logic       gif_n;
	logic       jpeg_n;
	logic       png_n;
	logic       bmp_n;
	logic       plain_n;
	logic       gif_bad;

	assign low = data_byte | 8'h20;

	always_comb begin
		case (prog_q)
			3'd1:    tail_chr = "h";
			3'd2:    tail_chr = "t";
			3'd3:    tail_chr = "m";
			default: tail_chr = "l";
		endcase
	end

	always_comb begin
		case (pos_q[2:0])
			3'd0:    png_chr = 8'h89;
			3'd1:    png_chr = "P";
			3'd2:    png_chr = "N";
			3'd3:    png_chr = "G";
			3'd4:    png_chr = 8'h0d;
			3'd5:    png_chr = 8'h0a;
			3'd6:    png_chr = 8'h1a;
			default: png_chr = 8'h0a;
		endcase
	end

	// "<html" search; a corrupt progress above four falls through to restart
	assign html_adv = (prog_q >= 3'd1) && (prog_q <= 3'd4) && (low == tail_chr);
	assign seen_n   = seen_q | (html_adv && (prog_q == 3'd4));

	always_comb begin
		if (html_adv) begin
			prog_n = (prog_q == 3'd4) ? 3'd0 : prog_q + 3'd1;
		end else begin
			prog_n = (data_byte == "<") ? 3'd1 : 3'd0;
		end
	end

	always_comb begin
		case (pos_q)
			4'd0:    gif_bad = (low != "g");
			4'd1:    gif_bad = (low != "i");
			4'd2:    gif_bad = (low != "f");
			4'd3:    gif_bad = (data_byte != "8");
			4'd4:    gif_bad = (data_byte != "7") && (data_byte != "9");
			4'd5:    gif_bad = (low != "a");
			default: gif_bad = 1'b0;
		endcase
	end

	assign gif_n  = gif_q & ~gif_bad;
	assign jpeg_n = jpeg_q
		& ~((pos_q == 4'd0) && (data_byte != 8'hff))
		& ~((pos_q == 4'd1) && (data_byte != 8'hd8));
	assign png_n  = png_q & ~((pos_q < 4'd8) && (data_byte != png_chr));
	assign bmp_n  = bmp_q
		& ~((pos_q == 4'd0) && (data_byte != 8'h42))
		& ~((pos_q == 4'd1) && (data_byte != 8'h4d))
		& ~((pos_q >= 4'd6) && (pos_q <= 4'd9) && (data_byte != 8'h00));
	// final byte is not examined for control codes
	assign plain_n = plain_q & ~(!last_byte && (data_byte < 8'h20)
		&& (data_byte != 8'h0a) && (data_byte != 8'h0d) && (data_byte != 8'h09));

	always_comb begin
		hits.html  = seen_n;
		hits.gif   = gif_n  && (pos_q >= 4'd5);
		hits.jpeg  = jpeg_n && (pos_q >= 4'd2);
		hits.png   = png_n  && (pos_q >= 4'd8);
		hits.bmp   = bmp_n  && (pos_q >= 4'd13);
		hits.plain = plain_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 4'd0;
			prog_q  <= 3'd0;
			seen_q  <= 1'b0;
			gif_q   <= 1'b1;
			jpeg_q  <= 1'b1;
			png_q   <= 1'b1;
			bmp_q   <= 1'b1;
			plain_q <= 1'b1;
		end else if (consume) begin
			if (last_byte) begin
				pos_q   <= 4'd0;
				prog_q  <= 3'd0;
				seen_q  <= 1'b0;
				gif_q   <= 1'b1;
				jpeg_q  <= 1'b1;
				png_q   <= 1'b1;
				bmp_q   <= 1'b1;
				plain_q <= 1'b1;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 4'd1;
				end
				prog_q  <= prog_n;
				seen_q  <= seen_n;
				gif_q   <= gif_n;
				jpeg_q  <= jpeg_n;
				png_q   <= png_n;
				bmp_q   <= bmp_n;
				plain_q <= plain_n;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_byte |=> (pos_q == 4'd0) && (prog_q == 3'd0) && !seen_q)
		else $error("scan state not cleared after final byte");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		consume && !last_byte && (pos_q == POS_MAX) |=> pos_q == POS_MAX)
		else $error("byte position wrapped");

	a_prog_range: assert property (@(posedge clk) disable iff (!arst_n)
		prog_q <= 3'd4)
		else $error("html progress out of range");

endmodule
`default_nettype wire

// ----- hdl/mts_select.sv -----
`default_nettype none
module mts_select (
	input  wire mts_pkg::mts_hits_t hits,
	input  wire logic [3:0]         proposed_type,
	output logic [2:0]              mime_type
);
	import mts_pkg::*;

	logic [3:0] prop_c;
	logic [7:0] hit_v;
	logic [2:0] prop_m;
	logic [2:0] first;

	// codes above other string are taken as other string
	assign prop_c = (proposed_type > PROP_OTHER) ? PROP_OTHER : proposed_type;
	assign prop_m = 3'(prop_c - 4'd1);
	assign hit_v  = {1'b0, 1'b1, hits.plain, hits.bmp, hits.png,
		hits.jpeg, hits.gif, hits.html};

	always_comb begin
		if (hits.html)       first = MIME_HTML;
		else if (hits.gif)   first = MIME_GIF;
		else if (hits.jpeg)  first = MIME_JPEG;
		else if (hits.png)   first = MIME_PNG;
		else if (hits.bmp)   first = MIME_BMP;
		else if (hits.plain) first = MIME_PLAIN;
		else                 first = MIME_OCTET;
	end

	always_comb begin
		if (prop_c == PROP_OTHER) begin
			mime_type = MIME_OTHER;
		end else if ((prop_c >= PROP_HTML) && (prop_c <= PROP_PLAIN) && hit_v[prop_m]) begin
			mime_type = prop_m;
		end else begin
			mime_type = first;
			if (prop_c != PROP_NONE) begin
				if (first == MIME_OCTET) begin
					mime_type = prop_m;
				end
				if ((prop_c == PROP_HTML) && (first == MIME_PLAIN)) begin
					mime_type = MIME_HTML;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mime_type_sniffer_unit.sv -----
`default_nettype none
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------
// input    | in_valid / in_ready  | data_byte, last_byte, proposed_type
// output   | out_valid / out_ready| mime_type (one per buffer)
//
// One byte per cycle sustained while no final byte waits on a stalled result;
// the scan state updates as each byte leaves the input register.
// The result is registered as the final byte leaves the input register, held in
// the result register until taken.
// A final byte waits in the input register only while an older result is
// still stalled; other bytes never wait on the output side.
// Reset (arst_n low) returns the scan flags and position to their start values and clears both valid bits.
module mime_type_sniffer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic [3:0] proposed_type,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      mime_type
);
	import mts_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic [3:0] prop_s1;

	// result register
	logic       out_valid_q;
	logic [2:0] mime_q;

	logic       out_free;
	logic       consume;
	mts_hits_t  hits;
	logic [2:0] mime_sel;

	assign out_free = !out_valid_q || out_ready;
	// non-final bytes retire unconditionally; the final one needs a free slot
	assign consume  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
			prop_s1 <= proposed_type;
		end
	end

	mts_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.consume   (consume),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.hits      (hits)
	);

	mts_select u_select (
		.hits          (hits),
		.proposed_type (prop_s1),
		.mime_type     (mime_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			mime_q <= mime_sel;
		end
	end

	assign out_valid = out_valid_q;
	assign mime_type = mime_q;

	a_final_blocks_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !out_ready |-> !in_ready && !consume)
		else $error("final byte retired over a stalled result");

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> out_valid_q)
		else $error("final byte retired without a result");

endmodule
`default_nettype wire

// ----- verif/mime_type_sniffer_unit_tb.sv -----
module mime_type_sniffer_unit_tb;
	import mts_pkg::*;

	// proposed codes the package leaves out
	localparam logic [3:0] PROP_GIF   = 4'd2;
	localparam logic [3:0] PROP_JPEG  = 4'd3;
	localparam logic [3:0] PROP_PNG   = 4'd4;
	localparam logic [3:0] PROP_BMP   = 4'd5;
	localparam logic [3:0] PROP_OCTET = 4'd7;
	localparam logic [3:0] PROP_TOP   = 4'd15;

	// magic bytes
	localparam logic [63:0] PNG_SIG   = 64'h89504E470D0A1A0A;
	localparam logic [31:0] HTML_TAIL = "html";

	localparam int DIRECTED_ROWS   = 22;
	localparam int RANDOM_BYTES    = 1900;
	localparam int CALM_AFTER      = 1650;  // no idling on either side past this
	localparam int PRESSURE_AT     = 300;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int DRAIN_CYCLES    = 8;

	// one directed stimulus row; want is only trusted when known is set
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [3:0] prop;
		logic       known;
		logic [2:0] want;
	} sniff_row_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte     = 8'h00;
	logic       last_byte     = 1'b0;
	logic [3:0] proposed_type = PROP_NONE;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic [2:0] mime_type;

	// predictor state, mirrors the scan registers of the block
	logic [3:0] scan_pos;
	logic [2:0] html_step;
	logic       html_seen, gif_ok, jpeg_ok, png_ok, bmp_ok, plain_ok;

	logic [2:0] mime_due[$];   // types still owed by the block, oldest first
	logic [7:0] stream_q[$];   // buffer under construction
	logic [2:0] mime_want;
	int         mismatches   = 0;
	int         quiet_cycles = 0;
	int         random_bytes = 0;
	bit         calm         = 1'b0;
	bit         hold_long    = 1'b0;

	mime_type_sniffer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.proposed_type (proposed_type),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mime_type     (mime_type)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void clear_sniff();
		scan_pos  = 4'd0;
		html_step = 3'd0;
		html_seen = 1'b0;
		gif_ok    = 1'b1;
		jpeg_ok   = 1'b1;
		png_ok    = 1'b1;
		bmp_ok    = 1'b1;
		plain_ok  = 1'b1;
	endfunction

	// Advances the scan by one byte. Returns 1 with the type on the final byte.
	function automatic logic sniff_byte(input logic [7:0] b, input logic last,
			input logic [3:0] prop, output logic [2:0] kind);
		logic [7:0] lc;
		logic [3:0] p;
		logic [3:0] pt;
		logic [6:0] hits;
		lc   = b | 8'h20;
		p    = scan_pos;
		kind = MIME_OCTET;

		// case-folded "<html" search; a stale step above four counts as idle
		if (html_step >= 3'd1 && html_step <= 3'd4 &&
				lc == HTML_TAIL[31 - 8 * (int'(html_step) - 1) -: 8]) begin
			if (html_step == 3'd4) begin
				html_seen = 1'b1;
				html_step = 3'd0;
			end else begin
				html_step = html_step + 3'd1;
			end
		end else begin
			html_step = (b == "<") ? 3'd1 : 3'd0;
		end

		case (p)
			4'd0: if (lc != "g") gif_ok = 1'b0;
			4'd1: if (lc != "i") gif_ok = 1'b0;
			4'd2: if (lc != "f") gif_ok = 1'b0;
			4'd3: if (b != "8") gif_ok = 1'b0;
			4'd4: if (b != "7" && b != "9") gif_ok = 1'b0;
			4'd5: if (lc != "a") gif_ok = 1'b0;
			default: ;
		endcase
		if (p == 4'd0 && b != 8'hFF) jpeg_ok = 1'b0;
		if (p == 4'd1 && b != 8'hD8) jpeg_ok = 1'b0;
		if (p < 4'd8 && b != PNG_SIG[63 - 8 * int'(p) -: 8]) png_ok = 1'b0;
		if (p == 4'd0 && b != 8'h42) bmp_ok = 1'b0;
		if (p == 4'd1 && b != 8'h4D) bmp_ok = 1'b0;
		if (p >= 4'd6 && p <= 4'd9 && b != 8'h00) bmp_ok = 1'b0;
		// the final byte is never judged for text
		if (!last && b < 8'h20 && b != 8'h09 && b != 8'h0A && b != 8'h0D)
			plain_ok = 1'b0;

		if (!last) begin
			if (p < 4'd15) scan_pos = p + 4'd1;
			return 1'b0;
		end

		hits[MIME_HTML]  = html_seen;
		hits[MIME_GIF]   = gif_ok && p >= 4'd5;
		hits[MIME_JPEG]  = jpeg_ok && p >= 4'd2;
		hits[MIME_PNG]   = png_ok && p >= 4'd8;
		hits[MIME_BMP]   = bmp_ok && p >= 4'd13;
		hits[MIME_PLAIN] = plain_ok;
		hits[MIME_OCTET] = 1'b1;

		pt = (prop > PROP_OTHER) ? PROP_OTHER : prop;
		if (pt == PROP_OTHER) begin
			kind = MIME_OTHER;
		end else if (pt >= PROP_HTML && pt <= PROP_PLAIN && hits[pt - 4'd1]) begin
			// proposal confirmed by content
			kind = 3'(pt - 4'd1);
		end else begin
			for (int k = 6; k >= 0; k--)
				if (hits[k]) kind = 3'(k);
			if (pt != PROP_NONE) begin
				if (kind == MIME_OCTET) kind = 3'(pt - 4'd1);
				// html proposed over plain-looking text stays html
				if (pt == PROP_HTML && kind == MIME_PLAIN) kind = MIME_HTML;
			end
		end
		clear_sniff();
		return 1'b1;
	endfunction

	// Directed table. Final rows with known set carry a hand-worked type;
	// the rest are left to the predictor.
	function automatic sniff_row_t directed_row(input int i);
		case (i)
			// lone bytes: extremes of data and of the proposed code
			0:  return {8'hFF, 1'b1, PROP_NONE,  1'b1, MIME_PLAIN};
			1:  return {8'h00, 1'b1, PROP_OTHER, 1'b1, MIME_OTHER};
			2:  return {8'h7F, 1'b1, PROP_TOP,   1'b1, MIME_OTHER};
			// html proposed over text
			3:  return {"A",   1'b1, PROP_HTML,  1'b1, MIME_HTML};
			// control byte kills text, so only octet is left: proposal wins
			4:  return {8'h01, 1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			5:  return {"A",   1'b1, PROP_JPEG,  1'b1, MIME_JPEG};
			6:  return {8'h1F, 1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			7:  return {8'h80, 1'b1, PROP_OCTET, 1'b1, MIME_OCTET};
			// tag in mixed case that ends on the final byte
			8:  return {"<",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			9:  return {"H",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			10: return {"t",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			11: return {"M",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			12: return {"L",   1'b1, PROP_NONE,  1'b0, MIME_OCTET};
			// shortest gif
			13: return {"G",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			14: return {"I",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			15: return {"F",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			16: return {"8",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			17: return {"9",   1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			18: return {"a",   1'b1, PROP_NONE,  1'b0, MIME_OCTET};
			// shortest jpeg, png proposed but not matched
			19: return {8'hFF, 1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			20: return {8'hD8, 1'b0, PROP_NONE,  1'b0, MIME_OCTET};
			default: return {8'hFF, 1'b1, PROP_PNG, 1'b0, MIME_OCTET};
		endcase
	endfunction

	function automatic logic [7:0] any_case(input logic [7:0] ch);
		return $urandom_range(0, 1) ? (ch ^ 8'h20) : ch;
	endfunction

	// mostly printable, with the odd whitespace and rare control byte
	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 47))
			0: return 8'h09;
			1: return 8'h0A;
			2: return 8'h0D;
			3: return 8'($urandom_range(0, 31));
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	// Fills stream_q with one buffer: headers with random bodies, text with
	// or without a tag, tag near-misses, long buffers and plain noise.
	task automatic build_buffer();
		int shape;
		int spot;
		int cut;
		stream_q.delete();
		shape = $urandom_range(0, 9);
		case (shape)
			1: begin
				stream_q.push_back(any_case("G"));
				stream_q.push_back(any_case("I"));
				stream_q.push_back(any_case("F"));
				stream_q.push_back("8");
				stream_q.push_back($urandom_range(0, 1) ? "7" : "9");
				stream_q.push_back(any_case("A"));
				repeat ($urandom_range(0, 8)) stream_q.push_back(text_char());
			end
			2: begin
				stream_q.push_back(8'hFF);
				stream_q.push_back(8'hD8);
				repeat ($urandom_range(0, 8)) stream_q.push_back(8'($urandom));
			end
			3: begin
				for (int j = 0; j < 8; j++) stream_q.push_back(PNG_SIG[63 - 8 * j -: 8]);
				repeat ($urandom_range(0, 8)) stream_q.push_back(8'($urandom));
			end
			4: begin
				stream_q.push_back(8'h42);
				stream_q.push_back(8'h4D);
				repeat (4) stream_q.push_back(8'($urandom));
				repeat (4) stream_q.push_back(8'h00);
				repeat ($urandom_range(0, 10)) stream_q.push_back(8'($urandom));
			end
			5, 6: begin
				repeat ($urandom_range(0, 15)) stream_q.push_back(text_char());
				if ($urandom_range(0, 1)) begin
					stream_q.push_back("<");
					for (int j = 0; j < 4; j++)
						stream_q.push_back(any_case(HTML_TAIL[31 - 8 * j -: 8]));
				end
				repeat ($urandom_range(0, 15)) stream_q.push_back(text_char());
				if (stream_q.size() == 0) stream_q.push_back(text_char());
			end
			7: begin
				// restarts and broken tags for the html matcher
				repeat ($urandom_range(3, 16))
					case ($urandom_range(0, 5))
						0, 1: stream_q.push_back("<");
						2: stream_q.push_back(any_case("h"));
						3: stream_q.push_back(any_case("t"));
						4: stream_q.push_back(any_case("m"));
						default: stream_q.push_back($urandom_range(0, 3) ? any_case("l") : "x");
					endcase
			end
			8: repeat ($urandom_range(16, 40)) stream_q.push_back(text_char());
			9: repeat ($urandom_range(16, 40)) stream_q.push_back(8'($urandom));
			default: repeat ($urandom_range(1, 20)) stream_q.push_back(8'($urandom));
		endcase

		if (shape >= 1 && shape <= 4) begin
			// occasionally spoil one header bit or cut the buffer short
			if ($urandom_range(0, 5) == 0) begin
				spot = $urandom_range(0, (stream_q.size() < 10 ? stream_q.size() : 10) - 1);
				stream_q[spot] = stream_q[spot] ^ 8'(1 << $urandom_range(0, 7));
			end
			if ($urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, stream_q.size());
				while (stream_q.size() > cut) void'(stream_q.pop_back());
			end
		end
	endtask

	// Offers one byte, possibly after an idle burst, and waits for its
	// transfer. The predictor only sees bytes that have transferred.
	task automatic send_byte(input logic [7:0] b, input logic last,
			input logic [3:0] prop, input logic known, input logic [2:0] want);
		logic [2:0] kind;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		last_byte     <= last;
		proposed_type <= prop;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (sniff_byte(b, last, prop, kind))
			mime_due.push_back(known ? want : kind);
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch @%0t: %s", $time, what);
	endtask

	// Sender: reset, directed table, then random buffers until the byte
	// budget is spent; then drain and give the verdict.
	initial begin
		sniff_row_t row;
		logic [3:0] prop;
		clear_sniff();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_row(i);
			send_byte(row.data, row.last, row.prop, row.known, row.want);
		end

		while (random_bytes < RANDOM_BYTES) begin
			build_buffer();
			// mostly legal codes, now and then the out-of-range ones
			prop = ($urandom_range(0, 9) == 9) ? 4'($urandom_range(9, 15))
			                                    : 4'($urandom_range(0, 8));
			for (int k = 0; k < stream_q.size(); k++) begin
				// the proposed code only matters on the final byte; toggle it anyway
				send_byte(stream_q[k], k == stream_q.size() - 1,
					(k == stream_q.size() - 1) ? prop : 4'($urandom_range(0, 15)),
					1'b0, MIME_OCTET);
				random_bytes++;
				if (random_bytes == PRESSURE_AT) hold_long = 1'b1;
				if (random_bytes >= CALM_AFTER) calm = 1'b1;
			end
		end
		in_valid <= 1'b0;

		while (mime_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("mime_type_sniffer_unit regression: pass");
		else
			$display("mime_type_sniffer_unit regression: fail");
		$finish;
	end

	// Receiver: ready stretches broken by stall bursts, plus one long hold
	// so that a final byte backs up behind an untaken result.
	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// Result check and watchdog. Every output transfer is matched against
	// the oldest owed type; a long run with no transfer on either side ends
	// the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (mime_due.size() == 0) begin
					report_mismatch($sformatf("unexpected mime_type %0d", mime_type));
				end else begin
					mime_want = mime_due.pop_front();
					if (mime_type !== mime_want)
						report_mismatch($sformatf("mime_type %0d, wanted %0d",
							mime_type, mime_want));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_CYCLES) begin
					$display("timeout: no transfer for %0d cycles", quiet_cycles);
					$display("mime_type_sniffer_unit regression: fail");
					$finish;
				end
			end
		end
	end

endmodule

// ----- mime_type_sniffer_unit.f -----
hdl/mts_pkg.sv
hdl/mts_scan.sv
hdl/mts_select.sv
hdl/mime_type_sniffer_unit.sv
verif/mime_type_sniffer_unit_tb.sv
